// ===== sv/afc_pkg.sv =====
package afc_pkg;

	// Fixed field widths of the box and result transactions
	localparam int COORD_BITS = 16;
	localparam int EXT_BITS   = COORD_BITS - 1;
	localparam int NORM_BITS  = 16;
	localparam int OFF_BITS   = 16;
	localparam int OFF_SHIFT  = 14;

	// Plane register file
	localparam int PLANE_MAX  = 6;
	localparam int REG_BITS   = 64;
	localparam int ADDR_BITS  = 6;
	localparam int IDX_BITS   = 3;

	// Product and sum widths
	localparam int PD_BITS    = NORM_BITS + COORD_BITS;
	localparam int PR_BITS    = NORM_BITS + EXT_BITS;
	localparam int SUM_BITS   = (COORD_BITS + 20 > OFF_BITS + OFF_SHIFT + 4) ?
		COORD_BITS + 20 : OFF_BITS + OFF_SHIFT + 4;

	// Register indexes
	typedef enum logic [IDX_BITS-1:0] {
		REG_RIGHT  = 3'd0,
		REG_LEFT   = 3'd1,
		REG_TOP    = 3'd2,
		REG_BOTTOM = 3'd3,
		REG_NEAR   = 3'd4,
		REG_FAR    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic signed [COORD_BITS-1:0] center_z;
		logic [EXT_BITS-1:0]          extent_x;
		logic [EXT_BITS-1:0]          extent_y;
		logic [EXT_BITS-1:0]          extent_z;
	} box_t;

	typedef struct packed {
		logic                 visible;
		logic [PLANE_MAX-1:0] fail_mask;
	} result_t;

	// Payload handed from cell to cell
	typedef struct packed {
		box_t                 box;
		logic [PLANE_MAX-1:0] mask;
	} flow_t;

	typedef logic [REG_BITS-1:0] plane_reg_t;

endpackage

// ===== sv/afc_regs.sv =====
module afc_regs (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [afc_pkg::ADDR_BITS-1:0]           paddr,
	input  logic [afc_pkg::REG_BITS-1:0]            pwdata,
	output logic [afc_pkg::REG_BITS-1:0]            prdata,
	output logic                                    pready,
	output afc_pkg::plane_reg_t [afc_pkg::PLANE_MAX-1:0] planes
);
	import afc_pkg::*;

	plane_reg_t [PLANE_MAX-1:0] plane_q;
	logic [IDX_BITS-1:0]        idx;
	logic                       wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_BITS-1:ADDR_BITS-IDX_BITS];
	assign wr_en  = psel && penable && pwrite && pready;
	assign planes = plane_q;

	// Write the addressed plane; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (wr_en && (idx < IDX_BITS'(PLANE_MAX))) begin
			plane_q[idx] <= pwdata;
		end
	end

	// Read decode
	always_comb begin
		unique case (idx)
			REG_RIGHT:  prdata = plane_q[REG_RIGHT];
			REG_LEFT:   prdata = plane_q[REG_LEFT];
			REG_TOP:    prdata = plane_q[REG_TOP];
			REG_BOTTOM: prdata = plane_q[REG_BOTTOM];
			REG_NEAR:   prdata = plane_q[REG_NEAR];
			REG_FAR:    prdata = plane_q[REG_FAR];
			default:    prdata = '0;
		endcase
	end

	property p_write_lands;
		@(posedge clk) disable iff (!arst_n)
		(wr_en && idx < IDX_BITS'(PLANE_MAX)) |=> (plane_q[$past(idx)] == $past(pwdata));
	endproperty
	a_write_lands: assert property (p_write_lands)
		else $error("plane register write lost");

endmodule

// ===== sv/afc_cell.sv =====
module afc_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  afc_pkg::plane_reg_t plane,
	input  logic                valid_in,
	input  afc_pkg::flow_t      flow_in,
	output logic                valid_out,
	output afc_pkg::flow_t      flow_out
);
	import afc_pkg::*;

	logic signed [NORM_BITS-1:0] n_x, n_y, n_z;
	logic [NORM_BITS-1:0]        a_x, a_y, a_z;

	logic                        v_s1;
	flow_t                       flow_s1;
	logic signed [PD_BITS-1:0]   pd_x_s1, pd_y_s1, pd_z_s1;
	logic [PR_BITS-1:0]          pr_x_s1, pr_y_s1, pr_z_s1;
	logic signed [OFF_BITS-1:0]  off_s1;

	logic signed [SUM_BITS-1:0]  sum;
	logic                        fail;
	flow_t                       flow_nx;

	logic                        v_s2;
	flow_t                       flow_s2;

	// Unpack normal and take magnitudes; the most negative code wraps to 2^15
	assign n_x = plane[NORM_BITS-1:0];
	assign n_y = plane[2*NORM_BITS-1:NORM_BITS];
	assign n_z = plane[3*NORM_BITS-1:2*NORM_BITS];
	assign a_x = n_x[NORM_BITS-1] ? NORM_BITS'(-n_x) : n_x;
	assign a_y = n_y[NORM_BITS-1] ? NORM_BITS'(-n_y) : n_y;
	assign a_z = n_z[NORM_BITS-1] ? NORM_BITS'(-n_z) : n_z;

	// Stage 1: distance and radius products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		flow_s1 <= flow_in;
		pd_x_s1 <= PD_BITS'(n_x) * PD_BITS'(flow_in.box.center_x);
		pd_y_s1 <= PD_BITS'(n_y) * PD_BITS'(flow_in.box.center_y);
		pd_z_s1 <= PD_BITS'(n_z) * PD_BITS'(flow_in.box.center_z);
		pr_x_s1 <= PR_BITS'(a_x) * PR_BITS'(flow_in.box.extent_x);
		pr_y_s1 <= PR_BITS'(a_y) * PR_BITS'(flow_in.box.extent_y);
		pr_z_s1 <= PR_BITS'(a_z) * PR_BITS'(flow_in.box.extent_z);
		off_s1  <= plane[REG_BITS-1:REG_BITS-OFF_BITS];
	end

	// Box passes when distance plus radius is not negative
	always_comb begin
		sum = SUM_BITS'(pd_x_s1) + SUM_BITS'(pd_y_s1) + SUM_BITS'(pd_z_s1)
			+ $signed({{(SUM_BITS-PR_BITS){1'b0}}, pr_x_s1})
			+ $signed({{(SUM_BITS-PR_BITS){1'b0}}, pr_y_s1})
			+ $signed({{(SUM_BITS-PR_BITS){1'b0}}, pr_z_s1})
			- $signed({{(SUM_BITS-OFF_BITS-OFF_SHIFT){off_s1[OFF_BITS-1]}},
				off_s1, {OFF_SHIFT{1'b0}}});
		fail = sum[SUM_BITS-1];
	end

	// Fold this plane's verdict into the mask
	always_comb begin
		flow_nx           = flow_s1;
		flow_nx.mask[IDX] = flow_s1.mask[IDX] | fail;
	end

	// Stage 2: hand the updated transaction on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		flow_s2 <= flow_nx;
	end

	assign valid_out = v_s2;
	assign flow_out  = flow_s2;

endmodule

// ===== sv/aabb_frustum_cull_test.sv =====
// An accepted start passes through every plane cell in turn before the done strobe
// (a multiply stage and a sum-and-compare stage in each plane cell).
// Throughput: one box per cycle; busy stays low, so start may be high every cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: arst_n clears the plane registers to zero and drops all boxes in flight.
module aabb_frustum_cull_test #(
	parameter int PLANE_COUNT = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  afc_pkg::box_t                 box,
	output logic                          done,
	output afc_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [afc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [afc_pkg::REG_BITS-1:0]  pwdata,
	output logic [afc_pkg::REG_BITS-1:0]  prdata,
	output logic                          pready
);
	import afc_pkg::*;

	localparam int LAT = 2 * PLANE_COUNT;

	plane_reg_t [PLANE_MAX-1:0] planes;
	logic                       accept;
	logic                       chain_v [PLANE_COUNT+1];
	flow_t                      chain_d [PLANE_COUNT+1];

	afc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.planes  (planes)
	);

	// Feed the chain directly; every cell advances every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign chain_v[0]      = accept;
	assign chain_d[0].box  = box;
	assign chain_d[0].mask = '0;

	for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
		afc_cell #(
			.IDX (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.plane     (planes[k]),
			.valid_in  (chain_v[k]),
			.flow_in   (chain_d[k]),
			.valid_out (chain_v[k+1]),
			.flow_out  (chain_d[k+1])
		);
	end

	// Present the finished mask
	assign done             = chain_v[PLANE_COUNT];
	assign result.fail_mask = chain_d[PLANE_COUNT].mask;
	assign result.visible   = (chain_d[PLANE_COUNT].mask == '0);

	property p_latency;
		@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done;
	endproperty
	a_latency: assert property (p_latency)
		else $error("box lost in plane chain");

	property p_no_ghost;
		@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT);
	endproperty
	a_no_ghost: assert property (p_no_ghost)
		else $error("result without a matching box");

	property p_unused_planes;
		@(posedge clk) disable iff (!arst_n)
		done |-> ((result.fail_mask >> PLANE_COUNT) == '0);
	endproperty
	a_unused_planes: assert property (p_unused_planes)
		else $error("untested plane flagged as failing");

endmodule

// ===== tb/aabb_frustum_cull_test_tb.sv =====
module aabb_frustum_cull_test_tb;
	import afc_pkg::*;

	localparam int N_PLANES    = 6;
	localparam int LATENCY     = 2 * N_PLANES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 300;

	// Register slots past the plane file; writes there must be ignored
	localparam logic [IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

	// Q1.14 unit normal component
	localparam logic [NORM_BITS-1:0] NORM_ONE = 16'h4000;

	// Plane setups of the random phases
	typedef enum int {
		SET_FRUSTUM,
		SET_NOISE,
		SET_ALL_ONES,
		SET_ALL_ZERO,
		SET_EXTREME,
		SET_BURST
	} plane_set_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  start   = 1'b0;
	logic                  busy;
	box_t                  box     = '0;
	logic                  done;
	result_t               result;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [ADDR_BITS-1:0]  paddr   = '0;
	logic [REG_BITS-1:0]   pwdata  = '0;
	logic [REG_BITS-1:0]   prdata;
	logic                  pready;

	plane_reg_t planes [PLANE_MAX];
	result_t    pending_culls [$];
	int         errors        = 0;
	int         boxes_sent    = 0;
	int         culls_checked = 0;
	int         visible_seen  = 0;
	int         settings_used = 0;
	int         idle_pct      = 10;
	int         cycle_count   = 0;

	aabb_frustum_cull_test #(
		.PLANE_COUNT(N_PLANES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.box     (box),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, pending_culls.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Work out the cull result of one box against the current planes
	function automatic result_t predict_cull(input box_t b);
		longint               ctr [3];
		longint               ext [3];
		longint               nrm [3];
		longint               offs;
		longint               radius;
		longint               sdist;
		logic [PLANE_MAX-1:0] mask;
		result_t              res;
		ctr[0] = longint'($signed(b.center_x));
		ctr[1] = longint'($signed(b.center_y));
		ctr[2] = longint'($signed(b.center_z));
		ext[0] = longint'({1'b0, b.extent_x});
		ext[1] = longint'({1'b0, b.extent_y});
		ext[2] = longint'({1'b0, b.extent_z});
		mask = '0;
		for (int p = 0; p < N_PLANES && p < PLANE_MAX; p++) begin
			offs = longint'($signed(planes[p][REG_BITS-1 -: OFF_BITS]));
			radius = 0;
			sdist = 0;
			for (int k = 0; k < 3; k++) begin
				nrm[k] = longint'($signed(planes[p][NORM_BITS*k +: NORM_BITS]));
				radius += ext[k] * ((nrm[k] < 0) ? -nrm[k] : nrm[k]);
				sdist += nrm[k] * ctr[k];
			end
			sdist -= offs * (longint'(1) << OFF_SHIFT);
			if (!(-radius <= sdist))
				mask[p] = 1'b1;
		end
		res.visible = (mask == '0);
		res.fail_mask = mask;
		return res;
	endfunction

	function automatic plane_reg_t pack_plane(input logic [NORM_BITS-1:0] nx,
		input logic [NORM_BITS-1:0] ny, input logic [NORM_BITS-1:0] nz,
		input logic [OFF_BITS-1:0] off);
		return {off, nz, ny, nx};
	endfunction

	function automatic box_t make_box(input int cx, input int cy, input int cz,
		input int ex, input int ey, input int ez);
		box_t b;
		b.center_x = COORD_BITS'(cx);
		b.center_y = COORD_BITS'(cy);
		b.center_z = COORD_BITS'(cz);
		b.extent_x = EXT_BITS'(ex);
		b.extent_y = EXT_BITS'(ey);
		b.extent_z = EXT_BITS'(ez);
		return b;
	endfunction

	// Mix boxes over the whole field range with small boxes near the planes
	function automatic box_t random_box();
		if ($urandom_range(1) == 1)
			return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		return make_box(int'($urandom_range(0, 4095)) - 2048,
			int'($urandom_range(0, 4095)) - 2048,
			int'($urandom_range(0, 4095)) - 2048,
			$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
	endfunction

	function automatic plane_reg_t random_plane(input plane_set_t kind);
		case (kind)
			SET_NOISE:    return {$urandom, $urandom};
			SET_ALL_ONES: return '1;
			SET_ALL_ZERO: return '0;
			SET_EXTREME: begin
				if ($urandom_range(1) == 1)
					return {4{16'h8000}};
				return {4{16'h7fff}};
			end
			default: begin
				return pack_plane(NORM_BITS'(int'($urandom_range(0, 32768)) - 16384),
					NORM_BITS'(int'($urandom_range(0, 32768)) - 16384),
					NORM_BITS'(int'($urandom_range(0, 32768)) - 16384),
					OFF_BITS'(int'($urandom_range(0, 4096)) - 2048));
			end
		endcase
	endfunction

	// Compare each result against the oldest pending prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_culls.size() == 0) begin
				$error("result with no box pending: visible %0b fail_mask %b",
					result.visible, result.fail_mask);
				errors++;
			end else begin
				want = pending_culls.pop_front();
				culls_checked++;
				if (result.visible === 1'b1)
					visible_seen++;
				if (result.visible !== want.visible) begin
					$error("visible: expected %0b, got %0b", want.visible, result.visible);
					errors++;
				end
				if (result.fail_mask !== want.fail_mask) begin
					$error("fail_mask: expected %b, got %b", want.fail_mask,
						result.fail_mask);
					errors++;
				end
			end
		end
	end

	// Write one register with a setup and an access phase
	task automatic write_plane(input logic [IDX_BITS-1:0] idx, input plane_reg_t val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 3'b000});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (idx < PLANE_MAX)
			planes[idx] = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Read one register back and compare it with the shadow copy
	task automatic check_plane(input logic [IDX_BITS-1:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_BITS'({idx, 3'b000});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (prdata !== planes[idx]) begin
			$error("prdata[%0d]: expected %h, got %h", idx, planes[idx], prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one box, idling at random first, and log its prediction on acceptance
	task automatic send_box(input box_t b);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		box <= b;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_culls.push_back(predict_cull(b));
		boxes_sent++;
	endtask

	// Hold off the sender until every pending result has come
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_culls.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_planes(input plane_set_t kind);
		for (int i = 0; i < PLANE_MAX; i++)
			write_plane(reg_idx_t'(i), random_plane(kind));
		settings_used++;
	endtask

	// Zero planes after reset: every box passes, extremes included
	task automatic test_reset_planes();
		for (int i = 0; i < PLANE_MAX; i++)
			check_plane(reg_idx_t'(i));
		settings_used++;
		send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
		send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(make_box(-32768, 32767, 0, 32767, 0, 16384));
		send_box(make_box(0, 0, 0, 0, 0, 0));
		drain_results();
	endtask

	// Read back every plane, and check that the spare slots change nothing
	task automatic test_register_access();
		for (int i = 0; i < PLANE_MAX; i++)
			write_plane(reg_idx_t'(i), random_plane(SET_NOISE));
		for (int i = 0; i < PLANE_MAX; i++)
			check_plane(reg_idx_t'(i));
		write_plane(IDX_SPARE_LO, '1);
		write_plane(IDX_SPARE_HI, {$urandom, $urandom});
		for (int i = 0; i < PLANE_MAX; i++)
			check_plane(reg_idx_t'(i));
		settings_used++;
		for (int i = 0; i < 4; i++)
			send_box(random_box());
		drain_results();
	endtask

	// Touching contact, most negative normal, and field extremes
	task automatic test_directed_boxes();
		// right passes when cx >= -ex, left passes when cx <= ex
		write_plane(REG_RIGHT, pack_plane(NORM_ONE, '0, '0, '0));
		write_plane(REG_LEFT, pack_plane(16'h8000, '0, '0, '0));
		write_plane(REG_TOP, '0);
		write_plane(REG_BOTTOM, '0);
		write_plane(REG_NEAR, '0);
		write_plane(REG_FAR, '0);
		settings_used++;
		send_box(make_box(-100, 0, 0, 100, 0, 0));
		send_box(make_box(-100, 0, 0, 99, 0, 0));
		send_box(make_box(100, 0, 0, 100, 0, 0));
		send_box(make_box(101, 0, 0, 100, 0, 0));
		send_box(make_box(-32768, 0, 0, 0, 0, 0));
		send_box(make_box(32767, 0, 0, 0, 0, 0));
		send_box(make_box(-32768, 0, 0, 32767, 0, 0));
		send_box(make_box(32767, 0, 0, 32767, 0, 0));
		drain_results();

		// Extreme register contents on every plane
		write_plane(REG_RIGHT, {4{16'h7fff}});
		write_plane(REG_LEFT, {4{16'h8000}});
		write_plane(REG_TOP, '1);
		write_plane(REG_BOTTOM, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
		write_plane(REG_NEAR, pack_plane(16'h8000, 16'h8000, 16'h8000, 16'h7fff));
		write_plane(REG_FAR, pack_plane('0, '0, NORM_ONE, 16'h0100));
		settings_used++;
		send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
		send_box(make_box(32767, 32767, 32767, 0, 0, 0));
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(make_box(-32768, 32767, -32768, 0, 32767, 0));
		send_box(make_box(32767, -32768, 32767, 32767, 0, 32767));
		send_box(make_box(256, 0, 256, 0, 0, 0));
		send_box(make_box(0, 0, 255, 0, 0, 0));
		drain_results();
	endtask

	// Random boxes over several plane setups, one of them without idling
	task automatic test_random_boxes();
		plane_set_t kind;
		for (int ph = 0; ph < 6; ph++) begin
			kind = plane_set_t'(ph);
			load_planes(kind);
			idle_pct = (kind == SET_BURST) ? 0 : 10;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stop mid-phase once and let the pipeline run dry
				if (kind == SET_FRUSTUM && n == PHASE_ITEMS / 2)
					drain_results();
				send_box(random_box());
			end
			drain_results();
		end
		idle_pct = 10;
	endtask

	initial begin
		for (int i = 0; i < PLANE_MAX; i++)
			planes[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_planes();
		test_register_access();
		test_directed_boxes();
		test_random_boxes();

		// Let any stray result show up before the verdict
		drain_results();
		repeat (LATENCY + 4) @(posedge clk);

		$display("Culled %0d boxes under %0d plane settings: %0d visible, %0d with a plane failed.",
			culls_checked, settings_used, visible_seen, culls_checked - visible_seen);
		$display("Register writes, readback and spare-slot writes were covered; %0d boxes sent.",
			boxes_sent);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/afc_pkg.sv
sv/afc_regs.sv
sv/afc_cell.sv
sv/aabb_frustum_cull_test.sv
tb/aabb_frustum_cull_test_tb.sv
